/* rtl/core/adcseq_pkg.sv */
// Shared types and constants for the ADC conversion sequencer.
package adcseq_pkg;

  // Longest channel list a chain run can walk through.
  localparam int unsigned MaxChain     = 8;
  // Bits of a channel number that reach the converter.
  localparam int unsigned ChannelBits  = 5;
  // Width of one channel entry in the packed scan list.
  localparam int unsigned ChanFieldW   = 5;
  localparam int unsigned ScanListW    = MaxChain * ChanFieldW;
  localparam int unsigned ScanLenW     = 4;
  localparam int unsigned ChainPosW    = 3;
  localparam int unsigned TickW        = 16;
  localparam int unsigned SampleW      = 10;
  localparam int unsigned CfgIndexW    = 2;
  localparam int unsigned CfgDataW     = 40;
  localparam int unsigned InDataW      = 16;
  localparam int unsigned OutDataW     = 24;

  typedef enum logic [1:0] {
    OP_START_SINGLE = 2'd0,
    OP_START_CHAIN  = 2'd1,
    OP_CONV_DONE    = 2'd2,
    OP_TICK         = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BUSY      = 2'd1,
    ST_TIMEOUT   = 2'd2,
    ST_IDLE_DONE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MODE_SINGLE = 2'd0,
    MODE_TIMED  = 2'd1,
    MODE_CHAIN  = 2'd2
  } run_mode_e;

  typedef enum logic [CfgIndexW-1:0] {
    REG_EIGHT_BIT    = 2'd0,
    REG_TIMEOUT      = 2'd1,
    REG_SCAN_LENGTH  = 2'd2,
    REG_SCAN_LIST    = 2'd3
  } cfg_reg_e;

  // One result beat, highest field first.
  typedef struct packed {
    logic                 busy_res;
    logic                 notify;
    logic [ChainPosW-1:0] result_index;
    logic [SampleW-1:0]   result_value;
    logic                 result_valid;
    logic [ChanFieldW-1:0] start_channel;
    logic                 start_valid;
    status_e              status;
  } result_t;

endpackage

/* rtl/core/adc_conversion_sequencer_core.sv */
// ADC conversion sequencer: command stream in, one status/result beat out per command.
//
// Usage:
// Commands arrive on the s_axis channel: tuser carries the opcode (start single,
// start chain, conversion complete, tick) and tdata carries channel, timed flag and
// the raw 10-bit sample. Every accepted beat yields exactly one beat on m_axis,
// where tuser holds the status code and tdata the start request, the converted
// sample with its chain index, notify and the busy flag after the command.
// Configuration (eight-bit mode, timeout limit, scan length, scan channel list) is
// written through the cfg channel, which is always ready; write it only while the
// block is idle.
// The input register takes an accepted beat and the compute stage moves its result
// to the output register. Throughput is one beat per cycle unless m_axis stalls:
// the single compute stage updates the sequencer state and loads the output register,
// so back-to-back commands see each other's state updates.
// When m_axis stalls, the output register holds its beat and the input register
// keeps one more; s_axis_tready drops only when both are full.
// Reset clears the run state to idle and loads the register defaults (ten-bit
// samples, timeout 65535, scan length 1, all list entries channel 0).
module adc_conversion_sequencer_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Command stream.
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata: channel[4:0], timed[5], sample[15:6].
  input  logic [adcseq_pkg::InDataW-1:0]    s_axis_tdata_i,
  // tuser: opcode[1:0].
  input  logic [1:0]                        s_axis_tuser_i,
  // Result stream.
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // tdata: start_valid[0], start_channel[5:1], result_valid[6], result_value[16:7],
  //        result_index[19:17], notify[20], busy_res[21], zero padding[23:22].
  output logic [adcseq_pkg::OutDataW-1:0]   m_axis_tdata_o,
  // tuser: status[1:0].
  output logic [1:0]                        m_axis_tuser_o,
  // Configuration writes.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [adcseq_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [adcseq_pkg::CfgDataW-1:0]   cfg_data_i
);
  import adcseq_pkg::*;

  localparam logic [ChanFieldW-1:0] ChanMask = ChanFieldW'((1 << ChannelBits) - 1);
  localparam logic [ScanLenW-1:0]   MaxLen   = ScanLenW'(MaxChain);

  // Configuration registers.
  logic                  eight_bit_q;
  logic [TickW-1:0]      timeout_q;
  logic [ScanLenW-1:0]   scan_len_q;
  logic [ScanListW-1:0]  scan_list_q;

  // Sequencer state.
  logic                  busy_q, busy_d;
  run_mode_e             mode_q, mode_d;
  logic [ChainPosW-1:0]  chain_pos_q, chain_pos_d;
  logic [TickW-1:0]      tick_q, tick_d;

  // Input register.
  logic                  in_valid_q;
  opcode_e               in_op_q;
  logic [ChanFieldW-1:0] in_chan_q;
  logic                  in_timed_q;
  logic [SampleW-1:0]    in_sample_q;

  // Output register.
  logic                  out_valid_q;
  result_t               out_q, res_d;

  logic                  out_ready;
  logic                  step;
  logic                  in_take;

  // The compute stage moves one command into the output register when it can.
  assign out_ready       = !out_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && out_ready;
  assign s_axis_tready_o = !in_valid_q || out_ready;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  // Configuration write decode.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eight_bit_q <= 1'b0;
      timeout_q   <= '1;
      scan_len_q  <= ScanLenW'(1);
      scan_list_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_EIGHT_BIT:   eight_bit_q <= cfg_data_i[0];
        REG_TIMEOUT:     timeout_q   <= cfg_data_i[TickW-1:0];
        REG_SCAN_LENGTH: scan_len_q  <= cfg_data_i[ScanLenW-1:0];
        REG_SCAN_LIST:   scan_list_q <= cfg_data_i[ScanListW-1:0];
        default: ;
      endcase
    end
  end

  // Effective chain length: zero counts as one, long lists are clipped.
  logic [ScanLenW-1:0]   eff_len;
  logic [ScanLenW-1:0]   next_pos;
  logic [TickW:0]        tick_inc;
  logic [TickW-1:0]      limit;

  assign eff_len  = (scan_len_q == '0) ? ScanLenW'(1) :
                    (scan_len_q > MaxLen) ? MaxLen : scan_len_q;
  assign next_pos = ScanLenW'(chain_pos_q) + ScanLenW'(1);
  assign tick_inc = {1'b0, tick_q} + (TickW+1)'(1);
  assign limit    = (timeout_q == '0) ? TickW'(1) : timeout_q;

  always_comb begin
    busy_d      = busy_q;
    mode_d      = mode_q;
    chain_pos_d = chain_pos_q;
    tick_d      = tick_q;
    res_d       = '0;
    res_d.status = ST_OK;

    case (in_op_q) inside
      OP_START_SINGLE, OP_START_CHAIN: begin
        if (busy_q) begin
          res_d.status = ST_BUSY;
        end else begin
          busy_d            = 1'b1;
          tick_d            = '0;
          chain_pos_d       = '0;
          res_d.start_valid = 1'b1;
          if (in_op_q == OP_START_SINGLE) begin
            mode_d              = in_timed_q ? MODE_TIMED : MODE_SINGLE;
            res_d.start_channel = in_chan_q & ChanMask;
          end else begin
            mode_d              = MODE_CHAIN;
            res_d.start_channel = scan_list_q[ChanFieldW-1:0] & ChanMask;
          end
        end
      end
      OP_CONV_DONE: begin
        if (!busy_q) begin
          res_d.status = ST_IDLE_DONE;
        end else begin
          res_d.result_valid = 1'b1;
          res_d.result_value = eight_bit_q ? (in_sample_q >> 2) : in_sample_q;
          if (mode_q == MODE_CHAIN) begin
            res_d.result_index = chain_pos_q;
            if (next_pos < eff_len) begin
              chain_pos_d         = next_pos[ChainPosW-1:0];
              res_d.start_valid   = 1'b1;
              res_d.start_channel =
                scan_list_q[int'(next_pos[ChainPosW-1:0])*ChanFieldW +: ChanFieldW]
                & ChanMask;
            end else begin
              chain_pos_d  = '0;
              busy_d       = 1'b0;
              res_d.notify = 1'b1;
            end
          end else begin
            busy_d       = 1'b0;
            tick_d       = '0;
            res_d.notify = 1'b1;
          end
        end
      end
      default: begin
        // Ticks only matter to a running timed single conversion.
        if (busy_q && mode_q == MODE_TIMED) begin
          if (tick_inc >= {1'b0, limit}) begin
            res_d.status = ST_TIMEOUT;
            busy_d       = 1'b0;
            tick_d       = '0;
          end else begin
            tick_d = tick_inc[TickW-1:0];
          end
        end
      end
    endcase

    res_d.busy_res = busy_d;
  end

  // Sequencer state and handshake flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      mode_q      <= MODE_SINGLE;
      chain_pos_q <= '0;
      tick_q      <= '0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        busy_q      <= busy_d;
        mode_q      <= mode_d;
        chain_pos_q <= chain_pos_d;
        tick_q      <= tick_d;
      end
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_op_q     <= opcode_e'(s_axis_tuser_i);
      in_chan_q   <= s_axis_tdata_i[4:0];
      in_timed_q  <= s_axis_tdata_i[5];
      in_sample_q <= s_axis_tdata_i[15:6];
    end
    if (step) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tdata_o  = {2'b00, out_q.busy_res, out_q.notify, out_q.result_index,
                            out_q.result_value, out_q.result_valid,
                            out_q.start_channel, out_q.start_valid};

  // The sequencer only leaves a run when a command is processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> $past(step))
    else $error("busy dropped without a processed command");

  // An idle sequencer always rests at the head of the channel list.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> chain_pos_q == '0)
    else $error("chain position not cleared while idle");

  // A finished run leaves the sequencer idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && res_d.notify) |=> !busy_q)
    else $error("still busy after notify");

  // The reported busy flag matches the state the command left behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_q.busy_res == busy_q)
    else $error("busy_res disagrees with sequencer state");

endmodule

/* tb/tb_adc_conversion_sequencer_core.sv */
// Self-checking testbench for the ADC conversion sequencer core.
`timescale 1ns / 100ps

module tb_adc_conversion_sequencer_core;
  import adcseq_pkg::*;

  // Cycles without any accepted beat on any channel before the run is declared hung.
  localparam int unsigned QuietLimit = 1000;
  // The closing wait leaves room for a stray beat.
  localparam int unsigned TailCycles = 8;
  localparam int unsigned PhaseItems = 90;
  localparam int unsigned RandomPhases = 8;

  // The scoreboard keeps its own copy of the sequencer state and of the register
  // file. Every command beat accepted by the block is stepped through that copy,
  // which queues the one result beat the block must return for it; result beats
  // are then checked in order against that queue.
  class conv_scoreboard;
    bit        eight_bit;
    bit [15:0] timeout_lim;
    bit [3:0]  scan_len;
    bit [39:0] scan_list;

    bit        busy;
    run_mode_e mode;
    bit [2:0]  chain_pos;
    bit [15:0] ticks;

    result_t   results_due[$];
    int        errors;
    int        beats_checked;
    int        status_count[4];

    function new();
      eight_bit   = 1'b0;
      timeout_lim = 16'hFFFF;
      scan_len    = 4'd1;
      scan_list   = '0;
      busy        = 1'b0;
      mode        = MODE_SINGLE;
      chain_pos   = '0;
      ticks       = '0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [39:0] data);
      case (idx)
        REG_EIGHT_BIT:   eight_bit   = data[0];
        REG_TIMEOUT:     timeout_lim = data[15:0];
        REG_SCAN_LENGTH: scan_len    = data[3:0];
        REG_SCAN_LIST:   scan_list   = data;
        default: ;
      endcase
    endfunction

    // A zero limit behaves like a limit of one.
    function int unsigned limit_eff();
      return (timeout_lim == 0) ? 1 : timeout_lim;
    endfunction

    // Scan length is clamped into 1..MaxChain.
    function int chain_len();
      if (scan_len == 0) return 1;
      if (scan_len > MaxChain) return MaxChain;
      return int'(scan_len);
    endfunction

    function bit [4:0] list_chan(int p);
      return scan_list[p*5 +: 5];
    endfunction

    // Steps the sequencer by one command and queues the beat it must produce.
    // Returns 0 for a tick that the block simply ignores.
    function bit accept_command(opcode_e op, logic [4:0] ch, logic tm, logic [9:0] smp);
      result_t     r;
      bit          effective;
      int unsigned t;
      r = '0;
      effective = 1'b1;
      case (op) inside
        OP_START_SINGLE, OP_START_CHAIN: begin
          if (busy) begin
            r.status = ST_BUSY;
          end else begin
            busy  = 1'b1;
            ticks = '0;
            chain_pos = '0;
            r.start_valid = 1'b1;
            if (op == OP_START_SINGLE) begin
              mode = tm ? MODE_TIMED : MODE_SINGLE;
              r.start_channel = ch;
            end else begin
              mode = MODE_CHAIN;
              r.start_channel = list_chan(0);
            end
          end
        end
        OP_CONV_DONE: begin
          if (!busy) begin
            r.status = ST_IDLE_DONE;
          end else begin
            r.result_valid = 1'b1;
            r.result_value = eight_bit ? {2'b00, smp[9:2]} : smp;
            if (mode == MODE_CHAIN) begin
              r.result_index = chain_pos;
              if (int'(chain_pos) + 1 < chain_len()) begin
                chain_pos = chain_pos + 3'd1;
                r.start_valid = 1'b1;
                r.start_channel = list_chan(int'(chain_pos));
              end else begin
                chain_pos = '0;
                busy = 1'b0;
                r.notify = 1'b1;
              end
            end else begin
              busy  = 1'b0;
              ticks = '0;
              r.notify = 1'b1;
            end
          end
        end
        default: begin
          if (busy && mode == MODE_TIMED) begin
            t = ticks + 1;
            if (t >= limit_eff()) begin
              r.status = ST_TIMEOUT;
              busy  = 1'b0;
              ticks = '0;
            end else begin
              ticks = t[15:0];
            end
          end else begin
            effective = 1'b0;
          end
        end
      endcase
      r.busy_res = busy;
      results_due.push_back(r);
      return effective;
    endfunction

    function void compare_field(string what, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
    endfunction

    function void check_result(logic [OutDataW-1:0] data, logic [1:0] user);
      result_t want;
      result_t got;
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t ns: result beat with nothing expected, expected none,",
                 $time, " actual tdata %h tuser %h", data, user);
        return;
      end
      want = results_due.pop_front();
      got.status        = status_e'(user);
      got.start_valid   = data[0];
      got.start_channel = data[5:1];
      got.result_valid  = data[6];
      got.result_value  = data[16:7];
      got.result_index  = data[19:17];
      got.notify        = data[20];
      got.busy_res      = data[21];
      beats_checked++;
      status_count[want.status]++;
      compare_field("status", 16'(want.status), 16'(got.status));
      compare_field("start_valid", 16'(want.start_valid), 16'(got.start_valid));
      compare_field("start_channel", 16'(want.start_channel), 16'(got.start_channel));
      compare_field("result_valid", 16'(want.result_valid), 16'(got.result_valid));
      compare_field("result_value", 16'(want.result_value), 16'(got.result_value));
      compare_field("result_index", 16'(want.result_index), 16'(got.result_index));
      compare_field("notify", 16'(want.notify), 16'(got.notify));
      compare_field("busy_res", 16'(want.busy_res), 16'(got.busy_res));
      compare_field("tdata padding", 16'd0, 16'(data[23:22]));
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [InDataW-1:0]   s_axis_tdata_i = '0;
  logic [1:0]           s_axis_tuser_i = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata_o;
  logic [1:0]           m_axis_tuser_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;

  conv_scoreboard sb;
  // Percent chance per cycle that the sender holds back or the receiver stalls.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned commands_sent = 0;
  int unsigned counted_items = 0;
  int unsigned settings_used = 1;

  always #2 clk_i = ~clk_i;

  adc_conversion_sequencer_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // The receiver decides at each falling edge whether it takes a beat at the next
  // rising edge; result beats are checked at the rising edge where they are taken.
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
    end
  end

  // Ends a hung run: any accepted beat on any channel restarts the count.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t ns: no beat accepted for %0d cycles, %0d results outstanding",
             $time, QuietLimit, sb.results_due.size());
    $display("end of test: mismatches");
    $finish;
  end

  // Sends one command beat. Called at a falling edge, returns at a falling edge
  // with tvalid still high, so back-to-back beats never drop valid in between.
  task automatic send_cmd(opcode_e op, logic [4:0] ch, logic tm, logic [9:0] smp);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {smp, tm, ch};
    s_axis_tuser_i  <= op;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    commands_sent++;
    if (sb.accept_command(op, ch, tm, smp)) counted_items++;
    @(negedge clk_i);
  endtask

  // Holds the sender off until every outstanding result beat has been taken.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    do @(negedge clk_i); while (sb.results_due.size() != 0);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  // Writes the whole register file; only called with the block drained.
  task automatic load_settings(logic eight, logic [15:0] lim, logic [3:0] len,
                               logic [39:0] lst);
    write_reg(REG_EIGHT_BIT, {39'd0, eight});
    write_reg(REG_TIMEOUT, {24'd0, lim});
    write_reg(REG_SCAN_LENGTH, {36'd0, len});
    write_reg(REG_SCAN_LIST, lst);
    cfg_valid_i <= 1'b0;
    settings_used++;
    @(negedge clk_i);
  endtask

  // Mostly complete runs with random content: single starts (timed ones get a run
  // of ticks that may cross the limit), chain runs through the whole list, with
  // stray starts thrown in while busy. The rest is random noise and runs cut short.
  task automatic random_phase(int unsigned quota);
    int unsigned goal;
    int unsigned k;
    int unsigned hi;
    int unsigned n;
    logic        tm;
    goal = counted_items + quota;
    while (counted_items < goal) begin
      k = $urandom_range(99);
      if ($urandom_range(59) == 0) drain();
      if (k < 15) begin
        send_cmd(opcode_e'($urandom_range(3)), 5'($urandom), 1'($urandom), 10'($urandom));
      end else if (k < 55) begin
        tm = 1'($urandom);
        send_cmd(OP_START_SINGLE, 5'($urandom), tm, 10'($urandom));
        if (tm) begin
          hi = (sb.limit_eff() < 40) ? sb.limit_eff() : 40;
          n = $urandom_range(hi);
          repeat (n) send_cmd(OP_TICK, 5'($urandom), 1'($urandom), 10'($urandom));
        end
        if ($urandom_range(4) == 0) begin
          send_cmd(opcode_e'($urandom_range(1)), 5'($urandom), 1'($urandom), 10'($urandom));
        end
        if ($urandom_range(9) != 0) begin
          send_cmd(OP_CONV_DONE, 5'($urandom), 1'($urandom), 10'($urandom));
        end
      end else begin
        send_cmd(OP_START_CHAIN, 5'($urandom), 1'($urandom), 10'($urandom));
        for (int i = 0; i < sb.chain_len(); i++) begin
          if ($urandom_range(5) == 0) begin
            send_cmd(OP_TICK, 5'($urandom), 1'($urandom), 10'($urandom));
          end
          if ($urandom_range(7) == 0) begin
            send_cmd(opcode_e'($urandom_range(1)), 5'($urandom), 1'($urandom), 10'($urandom));
          end
          if ($urandom_range(12) == 0) break;
          send_cmd(OP_CONV_DONE, 5'($urandom), 1'($urandom), 10'($urandom));
        end
      end
    end
  endtask

  initial begin
    logic        eight;
    logic [15:0] lim;
    logic [3:0]  len;
    logic [39:0] lst;
    sb = new();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part on the reset defaults: ten-bit samples, the largest timeout,
    // a one-entry chain on channel 0.
    send_cmd(OP_START_SINGLE, 5'd0, 1'b0, 10'd0);
    send_cmd(OP_CONV_DONE, 5'd0, 1'b0, 10'd1023);
    send_cmd(OP_START_SINGLE, 5'd31, 1'b1, 10'd0);
    send_cmd(OP_TICK, 5'd0, 1'b0, 10'd0);
    // Starts while a conversion runs are refused and leave it running.
    send_cmd(OP_START_SINGLE, 5'd5, 1'b0, 10'd0);
    send_cmd(OP_START_CHAIN, 5'd0, 1'b0, 10'd0);
    send_cmd(OP_CONV_DONE, 5'd0, 1'b0, 10'd0);
    // Completion and tick arriving while idle.
    send_cmd(OP_CONV_DONE, 5'd0, 1'b0, 10'd555);
    send_cmd(OP_TICK, 5'd0, 1'b0, 10'd0);
    // A tick during a chain run is not counted.
    send_cmd(OP_START_CHAIN, 5'd0, 1'b0, 10'd0);
    send_cmd(OP_TICK, 5'd0, 1'b1, 10'd0);
    send_cmd(OP_CONV_DONE, 5'd0, 1'b0, 10'd512);
    drain();

    // Eight-bit mode, a zero limit (acts as one tick) and a scan length above
    // the maximum, which walks all eight list entries.
    load_settings(1'b1, 16'd0, 4'd9,
                  {5'd15, 5'd16, 5'd30, 5'd1, 5'd10, 5'd21, 5'd0, 5'd31});
    send_cmd(OP_START_SINGLE, 5'd21, 1'b1, 10'd0);
    send_cmd(OP_TICK, 5'd0, 1'b0, 10'd0);
    send_cmd(OP_TICK, 5'd0, 1'b0, 10'd0);
    send_cmd(OP_CONV_DONE, 5'd0, 1'b0, 10'd1023);
    send_cmd(OP_START_CHAIN, 5'd0, 1'b0, 10'd0);
    send_cmd(OP_CONV_DONE, 5'd0, 1'b0, 10'd1023);
    send_cmd(OP_CONV_DONE, 5'd0, 1'b0, 10'd0);
    send_cmd(OP_CONV_DONE, 5'd0, 1'b0, 10'd3);
    send_cmd(OP_CONV_DONE, 5'd0, 1'b0, 10'd1020);
    send_cmd(OP_CONV_DONE, 5'd0, 1'b0, 10'd682);
    send_cmd(OP_CONV_DONE, 5'd0, 1'b0, 10'd341);
    send_cmd(OP_CONV_DONE, 5'd0, 1'b0, 10'd4);
    send_cmd(OP_CONV_DONE, 5'd0, 1'b0, 10'd1019);
    drain();

    // Random phases: each one rewrites the registers (extremes first) and uses
    // one of the four idling patterns.
    for (int p = 0; p < RandomPhases; p++) begin
      eight = p[0];
      lst = {8'($urandom), 32'($urandom)};
      case (p)
        0: begin lim = 16'd1;     len = 4'd8; end
        1: begin lim = 16'hFFFF;  len = 4'd0; lst = '1; end
        2: begin lim = 16'd2;     len = 4'd1; end
        3: begin lim = 16'd0;     len = 4'd15; lst = '0; end
        4: begin lim = 16'($urandom_range(30, 3)); len = 4'($urandom_range(7, 2)); end
        5: begin lim = 16'($urandom); len = 4'($urandom_range(14, 9)); end
        6: begin lim = 16'($urandom_range(8, 1)); len = 4'($urandom_range(15)); end
        default: begin lim = 16'd12; len = 4'd3; end
      endcase
      load_settings(eight, lim, len, lst);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      random_phase(PhaseItems);
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (TailCycles) @(negedge clk_i);

    $display("Sent %0d command beats (%0d not ignored) across %0d register settings.",
             commands_sent, counted_items, settings_used);
    $display("Checked %0d result beats: %0d ok, %0d busy, %0d timeout, %0d idle completion.",
             sb.beats_checked, sb.status_count[ST_OK], sb.status_count[ST_BUSY],
             sb.status_count[ST_TIMEOUT], sb.status_count[ST_IDLE_DONE]);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/adcseq_pkg.sv
rtl/core/adc_conversion_sequencer_core.sv
tb/tb_adc_conversion_sequencer_core.sv
